FILE: rtl/nibble_accumulator_cpu_core_assert.svh
// assertion macros for the rtl of the nibble accumulator cpu core
`ifndef NIBBLE_ACCUMULATOR_CPU_CORE_ASSERT_SVH
`define NIBBLE_ACCUMULATOR_CPU_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/nac_pkg.sv
// types and constants of the nibble accumulator cpu core
`default_nettype none

package nac_pkg;

  localparam int unsigned NAC_MEM_DEPTH = 256;
  localparam int unsigned NAC_ADDR_W    = 8;
  localparam int unsigned NAC_NIB_W     = 4;
  localparam int unsigned NAC_CYC_W     = 3;
  localparam int unsigned NAC_CNT_W     = 32;

  localparam logic [NAC_CYC_W-1:0] CYC_FETCH = 3'd2;
  localparam logic [NAC_CYC_W-1:0] CYC_SHORT = 3'd3;
  localparam logic [NAC_CYC_W-1:0] CYC_JUMP  = 3'd4;
  localparam logic [NAC_CYC_W-1:0] CYC_LONG  = 3'd5;

  typedef enum logic [1:0] {
    REQ_EXEC  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_BOUNDS = 2'd1,
    ERR_OPCODE = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    OP_HLT = 4'd0,
    OP_LDA = 4'd1,
    OP_STA = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_JMP = 4'd5,
    OP_JZ  = 4'd6,
    OP_LDI = 4'd7
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP_HI,
    S_OP_LO,
    S_ADR_HI,
    S_ADR_LO,
    S_DATA
  } state_e;

  typedef struct packed {
    logic                  we;
    logic [NAC_ADDR_W-1:0] waddr;
    logic [NAC_NIB_W-1:0]  wdata;
    logic                  re;
    logic [NAC_ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/nac_req_if.sv
// request channel of the nibble accumulator cpu core
`default_nettype none

interface nac_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] mem_addr;
  logic [3:0] mem_data;

  modport source (output valid, output req_type, output mem_addr, output mem_data,
                  input ready);
  modport sink (input valid, input req_type, input mem_addr, input mem_data,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/nac_rsp_if.sv
// response channel of the nibble accumulator cpu core
`default_nettype none

interface nac_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  prog_counter;
  logic [3:0]  accumulator;
  logic        zero_flag;
  logic        halted_flag;
  logic [1:0]  error_code;
  logic [2:0]  step_cycles;
  logic [7:0]  instr_byte;
  logic [31:0] instr_total;
  logic [31:0] cycle_total;

  modport source (output valid, output prog_counter, output accumulator,
                  output zero_flag, output halted_flag, output error_code,
                  output step_cycles, output instr_byte, output instr_total,
                  output cycle_total, input ready);
  modport sink (input valid, input prog_counter, input accumulator,
                input zero_flag, input halted_flag, input error_code,
                input step_cycles, input instr_byte, input instr_total,
                input cycle_total, output ready);
endinterface

`default_nettype wire

FILE: rtl/nac_mem.sv
// nibble memory with one write and one registered read port, cleared by valid bits
`default_nettype none

module nac_mem #(
  parameter int unsigned MEM_DEPTH = nac_pkg::NAC_MEM_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire nac_pkg::mem_req_t              req_i,
  output logic [nac_pkg::NAC_NIB_W-1:0]       rdata_o
);
  import nac_pkg::*;

  localparam int unsigned IdxW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [NAC_NIB_W-1:0] mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_q;
  logic [NAC_NIB_W-1:0] rdata_q;
  logic                 rd_ok_q;
  logic                 wr_in;
  logic                 rd_in;
  logic [IdxW-1:0]      widx;
  logic [IdxW-1:0]      ridx;

  assign wr_in = req_i.we && ({1'b0, req_i.waddr} < (NAC_ADDR_W + 1)'(MEM_DEPTH));
  assign rd_in = req_i.re && ({1'b0, req_i.raddr} < (NAC_ADDR_W + 1)'(MEM_DEPTH));
  assign widx  = IdxW'(req_i.waddr);
  assign ridx  = IdxW'(req_i.raddr);

  always_ff @(posedge clk_i) begin
    if (wr_in) begin
      mem_q[widx] <= req_i.wdata;
    end
    rdata_q <= mem_q[ridx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (wr_in) begin
        vld_q[widx] <= 1'b1;
      end
      rd_ok_q <= rd_in && vld_q[ridx];
    end
  end

  assign rdata_o = rd_ok_q ? rdata_q : '0;

endmodule

`default_nettype wire

FILE: rtl/nibble_accumulator_cpu_core.sv
// One result transaction per request transaction. Requests pass a one-entry input stage, so
// a new request is taken while the previous one is still executing or its result waits.
// A write, register reset, no-op request, halted execute or out-of-range pc completes from
// the idle state; an instruction reads nibbles in turn from the memory, whose read data is
// registered: the opcode byte, then two address nibbles for JMP, JZ, STA, LDA, ADD and SUB,
// then a data nibble for LDA, ADD and SUB. Memory reads as zero after reset through per-entry
// valid bits, so no clearing pass is needed and requests are taken right after reset.
`default_nettype none

`include "nibble_accumulator_cpu_core_assert.svh"

module nibble_accumulator_cpu_core #(
  parameter int unsigned MEM_DEPTH = nac_pkg::NAC_MEM_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  nac_req_if.sink    req_i,
  nac_rsp_if.source  rsp_o
);
  import nac_pkg::*;

  state_e                state_q, state_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [1:0]            pend_req_q;
  logic [NAC_ADDR_W-1:0] pend_addr_q;
  logic [NAC_NIB_W-1:0]  pend_data_q;

  logic [NAC_ADDR_W-1:0] pc_q, pc_d;
  logic [NAC_NIB_W-1:0]  acc_q, acc_d;
  logic                  z_q, z_d;
  logic [NAC_ADDR_W-1:0] ir_q, ir_d;
  logic [NAC_ADDR_W-1:0] alat_q, alat_d;
  logic [NAC_NIB_W-1:0]  dlat_q, dlat_d;
  logic                  halt_q, halt_d;
  err_e                  err_q, err_d;
  logic [NAC_CNT_W-1:0]  icnt_q, icnt_d;
  logic [NAC_CNT_W-1:0]  ccnt_q, ccnt_d;
  logic [NAC_NIB_W-1:0]  ahi_q, ahi_d;

  logic                  out_vld_q, out_vld_d;
  logic [NAC_CYC_W-1:0]  out_cyc_q;
  logic [NAC_ADDR_W-1:0] out_pc_q;
  logic [NAC_NIB_W-1:0]  out_acc_q;
  logic                  out_z_q;
  logic                  out_halt_q;
  err_e                  out_err_q;
  logic [NAC_ADDR_W-1:0] out_ir_q;
  logic [NAC_CNT_W-1:0]  out_icnt_q;
  logic [NAC_CNT_W-1:0]  out_ccnt_q;

  mem_req_t              mreq;
  logic [NAC_NIB_W-1:0]  rdata;
  logic                  in_acc;
  logic                  start;
  logic                  done;
  logic                  count;
  logic [NAC_CYC_W-1:0]  cyc;
  logic                  bound;
  logic [NAC_ADDR_W-1:0] fetch_addr;
  logic [NAC_NIB_W-1:0]  acc_new;

  nac_mem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  assign start      = (state_q == S_IDLE) && pend_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !pend_vld_q || start;
  assign in_acc     = req_i.valid && req_i.ready;
  assign pend_vld_d = in_acc || (pend_vld_q && !start);
  assign bound      = {1'b0, pc_q} >= (NAC_ADDR_W + 1)'(MEM_DEPTH - 1);
  assign fetch_addr = {ahi_q, rdata};

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    acc_d   = acc_q;
    z_d     = z_q;
    ir_d    = ir_q;
    alat_d  = alat_q;
    dlat_d  = dlat_q;
    halt_d  = halt_q;
    err_d   = err_q;
    icnt_d  = icnt_q;
    ccnt_d  = ccnt_q;
    ahi_d   = ahi_q;
    mreq    = '0;
    mreq.raddr = pc_q;
    done    = 1'b0;
    count   = 1'b0;
    cyc     = '0;
    acc_new = acc_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (pend_req_q)
            REQ_EXEC: begin
              if (halt_q) begin
                done = 1'b1;
              end else if (bound) begin
                err_d  = ERR_BOUNDS;
                halt_d = 1'b1;
                done   = 1'b1;
              end else begin
                mreq.re = 1'b1;
                pc_d    = pc_q + 8'd1;
                state_d = S_OP_HI;
              end
            end
            REQ_WRITE: begin
              mreq.we    = 1'b1;
              mreq.waddr = pend_addr_q;
              mreq.wdata = pend_data_q;
              done       = 1'b1;
            end
            REQ_CLEAR: begin
              pc_d   = '0;
              acc_d  = '0;
              z_d    = 1'b0;
              ir_d   = '0;
              alat_d = '0;
              dlat_d = '0;
              halt_d = 1'b0;
              err_d  = ERR_NONE;
              icnt_d = '0;
              ccnt_d = '0;
              done   = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_OP_HI: begin
        ir_d    = {rdata, ir_q[3:0]};
        mreq.re = 1'b1;
        pc_d    = pc_q + 8'd1;
        state_d = S_OP_LO;
      end
      S_OP_LO: begin
        ir_d = {ir_q[7:4], rdata};
        unique case (op_e'(ir_q[7:4]))
          OP_HLT: begin
            halt_d  = 1'b1;
            cyc     = CYC_SHORT;
            count   = 1'b1;
            done    = 1'b1;
            state_d = S_IDLE;
          end
          OP_LDI: begin
            acc_d   = rdata;
            z_d     = (rdata == '0);
            cyc     = CYC_SHORT;
            count   = 1'b1;
            done    = 1'b1;
            state_d = S_IDLE;
          end
          OP_LDA, OP_STA, OP_ADD, OP_SUB, OP_JMP, OP_JZ: begin
            mreq.re = 1'b1;
            pc_d    = pc_q + 8'd1;
            state_d = S_ADR_HI;
          end
          default: begin
            err_d   = ERR_OPCODE;
            halt_d  = 1'b1;
            cyc     = CYC_FETCH;
            done    = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_ADR_HI: begin
        ahi_d   = rdata;
        mreq.re = 1'b1;
        pc_d    = pc_q + 8'd1;
        state_d = S_ADR_LO;
      end
      S_ADR_LO: begin
        unique case (op_e'(ir_q[7:4]))
          OP_JMP: begin
            pc_d    = fetch_addr;
            cyc     = CYC_JUMP;
            count   = 1'b1;
            done    = 1'b1;
            state_d = S_IDLE;
          end
          OP_JZ: begin
            if (z_q) begin
              pc_d = fetch_addr;
            end
            cyc     = CYC_LONG;
            count   = 1'b1;
            done    = 1'b1;
            state_d = S_IDLE;
          end
          OP_STA: begin
            mreq.we    = 1'b1;
            mreq.waddr = fetch_addr;
            mreq.wdata = acc_q;
            alat_d     = fetch_addr;
            dlat_d     = acc_q;
            cyc        = CYC_LONG;
            count      = 1'b1;
            done       = 1'b1;
            state_d    = S_IDLE;
          end
          default: begin
            mreq.re    = 1'b1;
            mreq.raddr = fetch_addr;
            alat_d     = fetch_addr;
            state_d    = S_DATA;
          end
        endcase
      end
      S_DATA: begin
        dlat_d = rdata;
        unique case (op_e'(ir_q[7:4]))
          OP_LDA:  acc_new = rdata;
          OP_ADD:  acc_new = acc_q + rdata;
          default: acc_new = acc_q - rdata;
        endcase
        acc_d   = acc_new;
        z_d     = (acc_new == '0);
        cyc     = CYC_LONG;
        count   = 1'b1;
        done    = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (count) begin
      icnt_d = icnt_q + 32'd1;
      ccnt_d = ccnt_q + NAC_CNT_W'(cyc);
    end
  end

  assign out_vld_d = done || (out_vld_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      pc_q       <= '0;
      acc_q      <= '0;
      z_q        <= 1'b0;
      ir_q       <= '0;
      alat_q     <= '0;
      dlat_q     <= '0;
      halt_q     <= 1'b0;
      err_q      <= ERR_NONE;
      icnt_q     <= '0;
      ccnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      pc_q       <= pc_d;
      acc_q      <= acc_d;
      z_q        <= z_d;
      ir_q       <= ir_d;
      alat_q     <= alat_d;
      dlat_q     <= dlat_d;
      halt_q     <= halt_d;
      err_q      <= err_d;
      icnt_q     <= icnt_d;
      ccnt_q     <= ccnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ahi_q <= ahi_d;
    if (in_acc) begin
      pend_req_q  <= req_i.req_type;
      pend_addr_q <= req_i.mem_addr;
      pend_data_q <= req_i.mem_data;
    end
    if (done) begin
      out_cyc_q  <= cyc;
      out_pc_q   <= pc_d;
      out_acc_q  <= acc_d;
      out_z_q    <= z_d;
      out_halt_q <= halt_d;
      out_err_q  <= err_d;
      out_ir_q   <= ir_d;
      out_icnt_q <= icnt_d;
      out_ccnt_q <= ccnt_d;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.prog_counter = out_pc_q;
  assign rsp_o.accumulator  = out_acc_q;
  assign rsp_o.zero_flag    = out_z_q;
  assign rsp_o.halted_flag  = out_halt_q;
  assign rsp_o.error_code   = out_err_q;
  assign rsp_o.step_cycles  = out_cyc_q;
  assign rsp_o.instr_byte   = out_ir_q;
  assign rsp_o.instr_total  = out_icnt_q;
  assign rsp_o.cycle_total  = out_ccnt_q;

  `NAC_ASSERT_IMP(a_done_slot_free, done && (state_q != S_IDLE), !out_vld_q, "result overwrites a pending transaction")
  `NAC_ASSERT_IMP(a_err_halts, err_q != ERR_NONE, halt_q, "error code without halt")
  `NAC_ASSERT_NXT(a_halted_pc_hold, start && (pend_req_q == REQ_EXEC) && halt_q, $stable(pc_q), "halted execute moved the pc")
  `NAC_ASSERT_IMP(a_data_op, state_q == S_DATA, (ir_q[7:4] == OP_LDA) || (ir_q[7:4] == OP_ADD) || (ir_q[7:4] == OP_SUB), "operand read for a non-load opcode")

endmodule

`default_nettype wire

FILE: tb/nibble_accumulator_cpu_core_test.sv
// self-checking testbench of the nibble accumulator cpu core: programs, steps and checks status
module nibble_accumulator_cpu_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nac_pkg::*;

  localparam int unsigned MEM_DEPTH = NAC_MEM_DEPTH;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned SEND_GAP [3] = '{25, 85, 0};
  localparam int unsigned SINK_STALL [3] = '{85, 25, 0};
  // two copies of the cpu state: one walked by the generator, one by accepted requests
  localparam int unsigned PLAN = 0;
  localparam int unsigned SEEN = 1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] addr;
    logic [3:0] data;
    logic       hold;
    logic [1:0] phase;
  } req_item_t;

  typedef struct packed {
    logic [7:0]  prog_counter;
    logic [3:0]  accumulator;
    logic        zero_flag;
    logic        halted_flag;
    logic [1:0]  error_code;
    logic [2:0]  step_cycles;
    logic [7:0]  instr_byte;
    logic [31:0] instr_total;
    logic [31:0] cycle_total;
  } cpu_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  nac_req_if req_if ();
  nac_rsp_if rsp_if ();

  nibble_accumulator_cpu_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  logic [3:0]  mem_img [2][MEM_DEPTH];
  logic [7:0]  pc_q [2];
  logic [3:0]  acc_q [2];
  logic        zero_q [2];
  logic        halt_q [2];
  err_e        err_q [2];
  logic [7:0]  ir_q [2];
  logic [31:0] instr_cnt_q [2];
  logic [31:0] cycle_cnt_q [2];

  req_item_t   req_backlog [$];
  cpu_status_t status_due [$];
  int unsigned n_taken = 0;
  int unsigned n_reported = 0;
  int unsigned n_fail = 0;
  int unsigned n_live = 0;
  int unsigned n_cycles = 0;
  logic [1:0]  gen_phase = '0;
  logic [1:0]  load_phase;
  logic        hold_next = 1'b0;

  function automatic logic [3:0] read_nibble(int unsigned s, logic [7:0] a);
    return (a < MEM_DEPTH) ? mem_img[s][a] : '0;
  endfunction

  function automatic void write_nibble(int unsigned s, logic [7:0] a, logic [3:0] d);
    if (a < MEM_DEPTH) mem_img[s][a] = d;
  endfunction

  function automatic logic [7:0] fetch_pair(int unsigned s);
    logic [3:0] hi;
    hi = read_nibble(s, pc_q[s]);
    pc_q[s] = pc_q[s] + 8'd1;
    fetch_pair = {hi, read_nibble(s, pc_q[s])};
    pc_q[s] = pc_q[s] + 8'd1;
  endfunction

  function automatic void clear_regs(int unsigned s);
    pc_q[s] = '0;
    acc_q[s] = '0;
    zero_q[s] = 1'b0;
    halt_q[s] = 1'b0;
    err_q[s] = ERR_NONE;
    ir_q[s] = '0;
    instr_cnt_q[s] = '0;
    cycle_cnt_q[s] = '0;
  endfunction

  function automatic cpu_status_t model_step(int unsigned s, logic [1:0] kind,
                                             logic [7:0] addr, logic [3:0] data);
    logic [2:0]  cyc;
    logic [7:0]  target;
    logic [3:0]  opc;
    cpu_status_t st;
    cyc = '0;
    if (kind == REQ_WRITE) begin
      write_nibble(s, addr, data);
    end else if (kind == REQ_CLEAR) begin
      clear_regs(s);
    end else if (kind == REQ_EXEC && !halt_q[s]) begin
      if (pc_q[s] >= MEM_DEPTH - 1) begin
        err_q[s] = ERR_BOUNDS;
        halt_q[s] = 1'b1;
      end else begin
        ir_q[s] = fetch_pair(s);
        cyc = CYC_FETCH;
        opc = ir_q[s][7:4];
        if (opc == OP_HLT) begin
          halt_q[s] = 1'b1;
          cyc = CYC_SHORT;
        end else if (opc == OP_LDI) begin
          acc_q[s] = ir_q[s][3:0];
          cyc = CYC_SHORT;
        end else if (opc <= OP_JZ) begin
          target = fetch_pair(s);
          cyc = CYC_LONG;
          case (opc)
            OP_LDA: acc_q[s] = read_nibble(s, target);
            OP_STA: write_nibble(s, target, acc_q[s]);
            OP_ADD: acc_q[s] = acc_q[s] + read_nibble(s, target);
            OP_SUB: acc_q[s] = acc_q[s] - read_nibble(s, target);
            OP_JMP: begin
              pc_q[s] = target;
              cyc = CYC_JUMP;
            end
            default: if (zero_q[s]) pc_q[s] = target;
          endcase
        end else begin
          err_q[s] = ERR_OPCODE;
          halt_q[s] = 1'b1;
        end
        if (opc == OP_LDA || opc == OP_ADD || opc == OP_SUB || opc == OP_LDI)
          zero_q[s] = (acc_q[s] == '0);
        if (err_q[s] != ERR_OPCODE) begin
          instr_cnt_q[s] = instr_cnt_q[s] + 32'd1;
          cycle_cnt_q[s] = cycle_cnt_q[s] + 32'(cyc);
        end
      end
    end
    st.prog_counter = pc_q[s];
    st.accumulator = acc_q[s];
    st.zero_flag = zero_q[s];
    st.halted_flag = halt_q[s];
    st.error_code = err_q[s];
    st.step_cycles = cyc;
    st.instr_byte = ir_q[s];
    st.instr_total = instr_cnt_q[s];
    st.cycle_total = cycle_cnt_q[s];
    return st;
  endfunction

  function automatic void add_req(logic [1:0] kind, logic [7:0] addr, logic [3:0] data);
    req_item_t it;
    if (kind == REQ_WRITE || kind == REQ_CLEAR || (kind == REQ_EXEC && !halt_q[PLAN]))
      n_live++;
    it.kind = kind;
    it.addr = addr;
    it.data = data;
    it.hold = hold_next;
    it.phase = gen_phase;
    hold_next = 1'b0;
    req_backlog.push_back(it);
    void'(model_step(PLAN, kind, addr, data));
  endfunction

  // mostly valid opcodes, some halts, some unknown codes
  function automatic logic [3:0] code_nibble();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return 4'($urandom_range(1, 7));
    if (r < 82) return OP_HLT;
    return 4'($urandom_range(15));
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (n_fail < MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  initial forever #6 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    req_item_t next_req;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.req_type <= REQ_EXEC;
      req_if.mem_addr <= '0;
      req_if.mem_data <= '0;
      load_phase <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_backlog.size() != 0 &&
          (!req_backlog[0].hold || (!req_if.valid && n_taken == n_reported)) &&
          $urandom_range(99) >= SEND_GAP[req_backlog[0].phase]) begin
        next_req = req_backlog.pop_front();
        req_if.valid <= 1'b1;
        req_if.req_type <= next_req.kind;
        req_if.mem_addr <= next_req.addr;
        req_if.mem_data <= next_req.data;
        load_phase <= next_req.phase;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= SINK_STALL[load_phase]);
    end
  end

  always @(posedge clk_i) begin
    cpu_status_t want;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        status_due.push_back(model_step(SEEN, req_if.req_type, req_if.mem_addr,
                                        req_if.mem_data));
        n_taken <= n_taken + 1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        n_reported <= n_reported + 1;
        if (status_due.size() == 0) begin
          if (n_fail < MAX_REPORTS) $error("result transaction with no request waiting");
          n_fail++;
        end else begin
          want = status_due.pop_front();
          check_field("prog_counter", want.prog_counter, rsp_if.prog_counter);
          check_field("accumulator", want.accumulator, rsp_if.accumulator);
          check_field("zero_flag", want.zero_flag, rsp_if.zero_flag);
          check_field("halted_flag", want.halted_flag, rsp_if.halted_flag);
          check_field("error_code", want.error_code, rsp_if.error_code);
          check_field("step_cycles", want.step_cycles, rsp_if.step_cycles);
          check_field("instr_byte", want.instr_byte, rsp_if.instr_byte);
          check_field("instr_total", want.instr_total, rsp_if.instr_total);
          check_field("cycle_total", want.cycle_total, rsp_if.cycle_total);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned n_first;
    int unsigned pick;
    logic [7:0]  pc_now;
    rst_ni <= 1'b0;
    for (int unsigned s = 0; s < 2; s++) begin
      clear_regs(s);
      for (int unsigned a = 0; a < MEM_DEPTH; a++) mem_img[s][a] = '0;
    end

    // ldi 15, add with wrap, sta to the top address, jmp near the top
    add_req(REQ_WRITE, 8'h00, OP_LDI);
    add_req(REQ_WRITE, 8'h01, 4'hf);
    add_req(REQ_WRITE, 8'h02, OP_ADD);
    add_req(REQ_WRITE, 8'h05, 4'h1);
    add_req(REQ_WRITE, 8'h06, OP_STA);
    add_req(REQ_WRITE, 8'h08, 4'hf);
    add_req(REQ_WRITE, 8'h09, 4'hf);
    add_req(REQ_WRITE, 8'h0a, OP_JMP);
    add_req(REQ_WRITE, 8'h0c, 4'hf);
    add_req(REQ_WRITE, 8'h0d, 4'hd);
    // sub whose address fetch wraps the pc through zero, then an unknown opcode
    add_req(REQ_WRITE, 8'hfd, OP_SUB);
    for (int i = 0; i < 7; i++) add_req(REQ_EXEC, 8'hff, 4'hf);
    // writes while halted, then a register reset and a jump to the pc bound
    add_req(REQ_WRITE, 8'h01, 4'h0);
    add_req(REQ_WRITE, 8'h0d, 4'hf);
    hold_next = 1'b1;
    add_req(REQ_CLEAR, 8'h00, 4'h0);
    for (int i = 0; i < 5; i++) add_req(REQ_EXEC, 8'h00, 4'h0);
    add_req(REQ_NOP, 8'hff, 4'hf);

    n_first = n_live;
    while (n_live < n_first + RANDOM_ITEMS) begin
      if ((n_live - n_first) / PHASE_ITEMS != gen_phase && gen_phase < 2) begin
        gen_phase = gen_phase + 2'd1;
        hold_next = 1'b1;
      end
      pick = $urandom_range(99);
      pc_now = pc_q[PLAN];
      if (halt_q[PLAN]) begin
        if (pick < 10) add_req(REQ_EXEC, 8'($urandom), 4'($urandom));
        else if (pick < 20) add_req(REQ_WRITE, 8'($urandom), 4'($urandom));
        else add_req(REQ_CLEAR, 8'($urandom), 4'($urandom));
      end else if (pick < 3) begin
        // jump into the last few addresses
        add_req(REQ_WRITE, pc_now, OP_JMP);
        add_req(REQ_WRITE, pc_now + 8'd1, 4'($urandom));
        add_req(REQ_WRITE, pc_now + 8'd2, 4'hf);
        add_req(REQ_WRITE, pc_now + 8'd3, 4'($urandom_range(13, 15)));
      end else if (pick < 55) begin
        add_req(REQ_EXEC, 8'($urandom), 4'($urandom));
      end else if (pick < 80) begin
        add_req(REQ_WRITE, pc_now + 8'($urandom_range(7)), code_nibble());
      end else if (pick < 88) begin
        add_req(REQ_WRITE, 8'($urandom), 4'($urandom));
      end else if (pick < 92) begin
        add_req(REQ_CLEAR, 8'($urandom), 4'($urandom));
      end else if (pick < 95) begin
        add_req(REQ_NOP, 8'($urandom), 4'($urandom));
      end else begin
        add_req(REQ_EXEC, 8'($urandom), 4'($urandom));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (req_backlog.size() != 0 || req_if.valid || n_taken != n_reported)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_fail == 0 && status_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
